### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

### rtl/kahm_pkg.sv
// ----------------------------------------------------------------------------
// kahm_pkg
// Types and constants of the keyed address hash map.
// ----------------------------------------------------------------------------
package kahm_pkg;
	localparam int BUCKETS      = 256;
	localparam int POOL_ENTRIES = 256;
	localparam int BW = $clog2(BUCKETS);
	localparam int EW = $clog2(POOL_ENTRIES);
	localparam int LW = $clog2(POOL_ENTRIES + 1);
	localparam int NBW = 9;
	localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);
	localparam int ENT_W = 32 + 32 + 32 + LW;

	localparam logic [1:0] CMD_PUT    = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MISS    = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_INVALID = 2'd3;

	typedef struct packed {
		logic [31:0]   key;
		logic [31:0]   addr;
		logic [31:0]   item;
		logic [LW-1:0] next;
	} entry_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [NBW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic          done;
		logic [BW-1:0] rem;
	} div_rsp_t;
endpackage

### rtl/kahm_ram.sv
// ----------------------------------------------------------------------------
// kahm_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module kahm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### rtl/kahm_mod.sv
// ----------------------------------------------------------------------------
// kahm_mod
// Restoring bit-serial remainder of a 32-bit key by the bucket count.
// ----------------------------------------------------------------------------
module kahm_mod (
	input  logic               clk,
	input  logic               arst_n,
	input  kahm_pkg::div_req_t req,
	output kahm_pkg::div_rsp_t rsp
);
	logic [31:0] dvd_q;
	logic [kahm_pkg::NBW:0] rem_q;
	logic [kahm_pkg::NBW-1:0] dvs_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [kahm_pkg::NBW:0] shifted;
	logic [kahm_pkg::NBW:0] diff;

	assign shifted = {rem_q[kahm_pkg::NBW-1:0], dvd_q[31]};
	assign diff = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				done_q <= 1'b0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					done_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			rem_q <= '0;
			// Out-of-range counts are clamped to one and to the bucket total.
			if (req.divisor == '0) dvs_q <= kahm_pkg::NBW'(1);
			else if (req.divisor > kahm_pkg::NBW'(kahm_pkg::BUCKETS))
				dvs_q <= kahm_pkg::NBW'(kahm_pkg::BUCKETS);
			else dvs_q <= req.divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			rem_q <= diff[kahm_pkg::NBW] ? shifted : diff;
		end
	end

	assign rsp = '{done: done_q, rem: rem_q[kahm_pkg::BW-1:0]};
endmodule

### rtl/keyed_address_hash_map_core.sv
// ----------------------------------------------------------------------------
// keyed_address_hash_map_core
// Chained hash map over a pool of entries, matched on key and IPv4 address.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   cmd, key, ip_addr, item_value
// out      output     out_valid/out_stall status, item_out
// cfg      input      cfg_we              cfg_data (num_buckets)
// An accepted beat first computes the bucket remainder, then reads the bucket head
// (S_HRD, S_HWT) and walks the chain, one memory read (S_EWT, S_ECHK) per link
// followed, the closing empty link of a non-empty chain included; an empty bucket
// goes straight to S_ECHK. A new entry, or an unlink behind a predecessor, adds
// the states S_FWT and S_FRD before the result.
// After reset a clearing pass initializes the head and link memories; no beat
// is accepted during it.
// A result waits in the output register; a new beat is taken only in the cycle
// after the previous result has left.
`include "assert_macros.svh"
module keyed_address_hash_map_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [31:0] key,
	input  logic [31:0] ip_addr,
	input  logic [31:0] item_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] item_out,
	input  logic        cfg_we,
	input  logic [8:0]  cfg_data
);
	localparam int LW = kahm_pkg::LW;
	localparam int EW = kahm_pkg::EW;
	localparam int BW = kahm_pkg::BW;

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_DIV  = 4'd2;
	localparam logic [3:0] S_HRD  = 4'd3;
	localparam logic [3:0] S_HWT  = 4'd4;
	localparam logic [3:0] S_EWT  = 4'd5;
	localparam logic [3:0] S_ECHK = 4'd6;
	localparam logic [3:0] S_FRD  = 4'd7;
	localparam logic [3:0] S_FWT  = 4'd8;
	localparam logic [3:0] S_OUT  = 4'd9;

	logic [3:0] state_q;
	logic [8:0] nb_q;
	logic [1:0] cmd_q;
	logic [31:0] key_q, addr_q, item_q;
	logic [BW-1:0] bkt_q;
	logic [LW-1:0] cur_q, prev_q, free_q, head_q;
	logic [LW:0] steps_q;
	logic [LW:0] clr_q;
	logic [LW-1:0] cur_next_q;

	kahm_pkg::div_req_t dreq;
	kahm_pkg::div_rsp_t drsp;

	logic          h_we;
	logic [BW-1:0] h_waddr, h_raddr;
	logic [LW-1:0] h_wdata, h_rdata;
	logic          e_we;
	logic [EW-1:0] e_waddr, e_raddr;
	kahm_pkg::entry_t e_wdata, e_rdata;

	logic accept;
	logic match;

	logic [1:0] st_q;
	logic [31:0] io_q;

	// Pending head and entry writes, issued in S_OUT; the predecessor link write goes out in S_FRD.
	logic pw_h_q, pw_e_q;
	logic [LW-1:0] pw_hdata_q;
	logic [EW-1:0] pw_eaddr_q;
	kahm_pkg::entry_t pw_edata_q;
	logic pw2_e_q;
	logic [EW-1:0] pw2_eaddr_q;
	kahm_pkg::entry_t pw2_edata;

	logic [EW-1:0] wr_addr;
	kahm_pkg::entry_t wr_data;
	logic wr_en;

	logic e_we_f;
	logic [EW-1:0] e_waddr_f;
	kahm_pkg::entry_t e_wdata_f;

	logic hw_en;
	logic [BW-1:0] hw_addr;
	logic [LW-1:0] hw_data;

	kahm_mod u_mod (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	kahm_ram #(.WIDTH(LW), .DEPTH(kahm_pkg::BUCKETS)) u_head (
		.clk(clk), .we(hw_en), .waddr(hw_addr), .wdata(hw_data),
		.raddr(h_raddr), .rdata(h_rdata));

	kahm_ram #(.WIDTH(kahm_pkg::ENT_W), .DEPTH(kahm_pkg::POOL_ENTRIES)) u_ent (
		.clk(clk), .we(e_we_f), .waddr(e_waddr_f), .wdata(e_wdata_f),
		.raddr(e_raddr), .rdata(e_rdata));

	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;
	assign out_valid = (state_q == S_OUT);
	assign match = (e_rdata.key == key_q) && (e_rdata.addr == addr_q);

	assign dreq.start = accept;
	assign dreq.dividend = key;
	assign dreq.divisor = nb_q;
	assign h_raddr = bkt_q;

	// Memory write and read-address selection per state.
	always_comb begin
		h_we = 1'b0;
		h_waddr = bkt_q;
		h_wdata = cur_q;
		e_we = 1'b0;
		e_waddr = cur_q[EW-1:0];
		e_wdata = e_rdata;
		e_raddr = cur_q[EW-1:0];
		case (state_q)
			S_CLR: begin
				if (clr_q < (LW+1)'(kahm_pkg::BUCKETS)) begin
					h_we = 1'b1;
					h_waddr = clr_q[BW-1:0];
					h_wdata = kahm_pkg::NIL;
				end
				if (clr_q < (LW+1)'(kahm_pkg::POOL_ENTRIES)) begin
					e_we = 1'b1;
					e_waddr = clr_q[EW-1:0];
					e_wdata = '0;
					e_wdata.next = LW'(clr_q + (LW+1)'(1));
				end
			end
			default: begin
			end
		endcase
	end

	assign status = st_q;
	assign item_out = io_q;

	// Predecessor data for unlink is read in S_FWT at prev; patch it in S_FRD.
	always_comb begin
		pw2_edata = e_rdata;
		pw2_edata.next = cur_next_q;
	end

	// Pending entry writes go out in S_FRD (predecessor link) and S_OUT.
	always_comb begin
		wr_en = 1'b0;
		wr_addr = pw_eaddr_q;
		wr_data = pw_edata_q;
		if (state_q == S_OUT && pw_e_q) wr_en = 1'b1;
		else if (state_q == S_FRD && pw2_e_q) begin
			wr_en = 1'b1;
			wr_addr = pw2_eaddr_q;
			wr_data = pw2_edata;
		end
	end

	assign e_we_f = e_we | wr_en;
	assign e_waddr_f = e_we ? e_waddr : wr_addr;
	assign e_wdata_f = e_we ? e_wdata : wr_data;

	// Head memory write port: clear pass or pending head update.
	assign hw_en = h_we | (state_q == S_OUT && pw_h_q);
	assign hw_addr = h_we ? h_waddr : bkt_q;
	assign hw_data = h_we ? h_wdata : pw_hdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			nb_q <= kahm_pkg::NBW'(kahm_pkg::BUCKETS);
			free_q <= '0;
			cur_q <= kahm_pkg::NIL;
			prev_q <= kahm_pkg::NIL;
			steps_q <= '0;
			st_q <= kahm_pkg::ST_OK;
			io_q <= '0;
			pw_h_q <= 1'b0;
			pw_e_q <= 1'b0;
			pw2_e_q <= 1'b0;
			pw_hdata_q <= '0;
			pw_eaddr_q <= '0;
			pw_edata_q <= '0;
			pw2_eaddr_q <= '0;
			cur_next_q <= '0;
		end else begin
			if (cfg_we) nb_q <= cfg_data;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + (LW+1)'(1);
					if (clr_q == (LW+1)'(kahm_pkg::BUCKETS > kahm_pkg::POOL_ENTRIES ?
					    kahm_pkg::BUCKETS - 1 : kahm_pkg::POOL_ENTRIES - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: if (accept) state_q <= S_DIV;
				S_DIV: if (drsp.done) state_q <= S_HRD;
				S_HRD: state_q <= S_HWT;
				S_HWT: begin
					cur_q <= h_rdata;
					prev_q <= kahm_pkg::NIL;
					steps_q <= '0;
					if (cmd_q == kahm_pkg::CMD_PUT && item_q == '0) begin
						st_q <= kahm_pkg::ST_INVALID;
						io_q <= '0;
						state_q <= S_OUT;
					end else if (cmd_q != kahm_pkg::CMD_PUT && cmd_q != kahm_pkg::CMD_LOOKUP &&
					    cmd_q != kahm_pkg::CMD_REMOVE) begin
						st_q <= kahm_pkg::ST_MISS;
						io_q <= '0;
						state_q <= S_OUT;
					end else if (h_rdata == kahm_pkg::NIL) state_q <= S_ECHK;
					else state_q <= S_EWT;
				end
				S_EWT: state_q <= S_ECHK;
				S_ECHK: begin
					if (cur_q != kahm_pkg::NIL &&
					    steps_q < (LW+1)'(kahm_pkg::POOL_ENTRIES) && match) begin
						st_q <= kahm_pkg::ST_OK;
						if (cmd_q == kahm_pkg::CMD_LOOKUP) begin
							io_q <= e_rdata.item;
							state_q <= S_OUT;
						end else if (cmd_q == kahm_pkg::CMD_PUT) begin
							io_q <= '0;
							pw_e_q <= 1'b1;
							pw_eaddr_q <= cur_q[EW-1:0];
							pw_edata_q <= '{key: e_rdata.key, addr: e_rdata.addr,
								item: item_q, next: e_rdata.next};
							state_q <= S_OUT;
						end else begin
							io_q <= '0;
							pw_e_q <= 1'b1;
							pw_eaddr_q <= cur_q[EW-1:0];
							pw_edata_q <= '{key: e_rdata.key, addr: e_rdata.addr,
								item: e_rdata.item, next: free_q};
							free_q <= cur_q;
							if (prev_q == kahm_pkg::NIL) begin
								pw_h_q <= 1'b1;
								pw_hdata_q <= e_rdata.next;
								state_q <= S_OUT;
							end else begin
								// Predecessor must be reread to rewrite its link.
								pw2_e_q <= 1'b1;
								pw2_eaddr_q <= prev_q[EW-1:0];
								cur_next_q <= e_rdata.next;
								cur_q <= prev_q;
								state_q <= S_FWT;
							end
						end
					end else if (cur_q != kahm_pkg::NIL &&
					    steps_q < (LW+1)'(kahm_pkg::POOL_ENTRIES)) begin
						prev_q <= cur_q;
						cur_q <= e_rdata.next;
						steps_q <= steps_q + (LW+1)'(1);
						state_q <= S_EWT;
					end else if (cmd_q == kahm_pkg::CMD_PUT && free_q != kahm_pkg::NIL) begin
						st_q <= kahm_pkg::ST_OK;
						io_q <= '0;
						cur_q <= free_q;
						state_q <= S_FWT;
					end else begin
						st_q <= (cmd_q == kahm_pkg::CMD_PUT) ? kahm_pkg::ST_FULL :
							kahm_pkg::ST_MISS;
						io_q <= '0;
						state_q <= S_OUT;
					end
				end
				S_FWT: state_q <= S_FRD;
				S_FRD: begin
					state_q <= S_OUT;
					if (pw2_e_q) begin
						pw2_e_q <= 1'b0;
					end else begin
						// Put of a new entry: pop free head, link at bucket head.
						free_q <= e_rdata.next;
						pw_e_q <= 1'b1;
						pw_eaddr_q <= cur_q[EW-1:0];
						pw_edata_q <= '{key: key_q, addr: addr_q, item: item_q, next: head_q};
						pw_h_q <= 1'b1;
						pw_hdata_q <= cur_q;
					end
				end
				S_OUT: begin
					pw_e_q <= 1'b0;
					pw_h_q <= 1'b0;
					if (!out_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			key_q <= key;
			addr_q <= ip_addr;
			item_q <= item_value;
		end
		if (state_q == S_DIV && drsp.done) bkt_q <= drsp.rem;
		if (state_q == S_HWT) head_q <= h_rdata;
	end

	`ASSERT_NEVER(a_no_accept_busy, clk, arst_n, accept && state_q != S_IDLE,
		"beat accepted while busy")
	`ASSERT_IMPL(a_out_hold, clk, arst_n,
		(out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(item_out)),
		"result dropped under stall")
	`ASSERT_IMPL(a_div_then_head, clk, arst_n,
		(state_q == S_DIV && drsp.done) |=> (state_q == S_HRD),
		"remainder not followed by head read")
endmodule
